// File: sv/sfp_pkg.sv
// Shared types and constants for the sensor frame parser.
package sfp_pkg;

  localparam logic [7:0] HEADER_BYTE = 8'h55;
  localparam int STORE_DEPTH = 12;                     // longest frame in bytes
  localparam int MIN_FRAME = 6;                        // shortest frame in bytes
  localparam int WORD_DEPTH = STORE_DEPTH / 2 - 1;     // words kept after header
  localparam int WORD_AW = $clog2(WORD_DEPTH);
  localparam int POS_W = $clog2(STORE_DEPTH + 1);

  // Word write from the parser into the frame store.
  typedef struct packed {
    logic               we;
    logic [WORD_AW-1:0] addr;
    logic [15:0]        data;
  } sfp_wr_t;

  // End-of-frame event: good frame with its last word index, or a failure.
  typedef struct packed {
    logic               valid;
    logic               ok;
    logic [WORD_AW-1:0] last_idx;
  } sfp_event_t;

endpackage

// File: sv/sensor_frame_parser_sum_check.sv
// Top level: byte stream in, checked frame words out.
// The closing checksum beat raises m_tvalid through the word store read and the output
//   load (RD_ISSUE, RD_LOAD) on a good frame, or at that beat's own edge on a failure.
// Throughput: 1 byte per cycle inside a frame; each word out passes through read, load and
//   hand off, plus output stalls; input is held off until the last word beat is taken.
// Reset (rst, synchronous, active high): hunting, sum and position cleared, short frame.
module sensor_frame_parser_sum_check #(
  parameter int SHORT_FRAME_BYTES = 10,
  parameter int LONG_FRAME_BYTES  = 12
) (
  input  logic        clk,
  input  logic        rst,
  // configuration: frame_format, 0 short angle frame, 1 long quaternion frame
  input  logic        cfg_we,
  input  logic        cfg_data,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] rx_byte
  // output stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [15:0] word_value, [18:16] word_index, rest zero
  output logic        m_tuser,   // frame_ok
  output logic        m_tlast    // last_word
);
  import sfp_pkg::*;

  logic       frame_format;
  logic       beat;
  logic       busy;
  sfp_wr_t    wr;
  sfp_event_t ev;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_format <= 1'b0;
    end else if (cfg_we) begin
      frame_format <= cfg_data;
    end
  end

  // One beat at a time: no new byte while a result is pending or being replayed.
  assign s_tready = !busy;
  assign beat     = s_tvalid && s_tready;

  sfp_parser #(
    .SHORT_FRAME_BYTES (SHORT_FRAME_BYTES),
    .LONG_FRAME_BYTES  (LONG_FRAME_BYTES)
  ) u_parser (
    .clk          (clk),
    .rst          (rst),
    .frame_format (frame_format),
    .beat         (beat),
    .rx_byte      (s_tdata),
    .wr           (wr),
    .ev           (ev)
  );

  sfp_readout u_readout (
    .clk      (clk),
    .rst      (rst),
    .wr       (wr),
    .ev       (ev),
    .busy     (busy),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

// File: sv/sfp_parser.sv
// Header hunt, byte position, running sum and checksum compare.
module sfp_parser #(
  parameter int SHORT_FRAME_BYTES = 10,
  parameter int LONG_FRAME_BYTES  = 12
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               frame_format,
  input  logic               beat,
  input  logic [7:0]         rx_byte,
  output sfp_pkg::sfp_wr_t    wr,
  output sfp_pkg::sfp_event_t ev
);
  import sfp_pkg::*;

  // Frame lengths clamped to the store and rounded down to even.
  localparam int SHORT_CL = (SHORT_FRAME_BYTES < MIN_FRAME) ? MIN_FRAME :
                            (SHORT_FRAME_BYTES > STORE_DEPTH) ? STORE_DEPTH :
                            SHORT_FRAME_BYTES;
  localparam int LONG_CL  = (LONG_FRAME_BYTES < MIN_FRAME) ? MIN_FRAME :
                            (LONG_FRAME_BYTES > STORE_DEPTH) ? STORE_DEPTH :
                            LONG_FRAME_BYTES;
  localparam logic [POS_W-1:0] SHORT_LEN = POS_W'((SHORT_CL / 2) * 2);
  localparam logic [POS_W-1:0] LONG_LEN  = POS_W'((LONG_CL / 2) * 2);

  typedef enum logic [1:0] {PH_HUNT, PH_HEAD2, PH_BODY} phase_t;

  phase_t           phase;
  logic [POS_W-1:0] pos;
  logic [15:0]      sum;
  logic [7:0]       hi;

  logic [POS_W-1:0] len;
  logic [15:0]      rx_word;
  logic [POS_W-1:0] half_len;

  assign len      = frame_format ? LONG_LEN : SHORT_LEN;
  assign rx_word  = {hi, rx_byte};
  assign half_len = len >> 1;

  always_comb begin
    wr       = '0;
    ev       = '0;
    wr.data  = rx_word;
    wr.addr  = WORD_AW'(pos[POS_W-1:1] - 1'b1);
    ev.ok    = (rx_word == sum);
    ev.last_idx = WORD_AW'(half_len - POS_W'(2));
    if (beat && phase == PH_BODY) begin
      if (pos >= len) begin
        ev.valid = 1'b1;
        ev.ok    = 1'b0;
      end else begin
        wr.we = pos[0];
        if (pos == len - POS_W'(1)) begin
          ev.valid = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_HUNT;
      pos   <= '0;
      sum   <= '0;
    end else if (beat) begin
      unique case (phase)
        PH_HUNT: begin
          if (rx_byte == HEADER_BYTE) begin
            sum   <= 16'(HEADER_BYTE);
            pos   <= POS_W'(1);
            phase <= PH_HEAD2;
          end
        end
        PH_HEAD2: begin
          if (rx_byte == HEADER_BYTE) begin
            sum   <= sum + 16'(HEADER_BYTE);
            pos   <= POS_W'(2);
            phase <= PH_BODY;
          end else begin
            sum   <= '0;
            pos   <= '0;
            phase <= PH_HUNT;
          end
        end
        default: begin
          if (pos >= len || pos == len - POS_W'(1)) begin
            sum   <= '0;
            pos   <= '0;
            phase <= PH_HUNT;
          end else begin
            if (pos < len - POS_W'(2)) begin
              sum <= sum + 16'(rx_byte);
            end
            pos <= pos + POS_W'(1);
          end
        end
      endcase
    end
  end

  // high byte of the word in progress
  always_ff @(posedge clk) begin
    if (beat && !pos[0]) begin
      hi <= rx_byte;
    end
  end

endmodule

// File: sv/sfp_readout.sv
// Frame word store and the output register that replays it after a good frame, or gives one failure beat.
module sfp_readout (
  input  logic                clk,
  input  logic                rst,
  input  sfp_pkg::sfp_wr_t    wr,
  input  sfp_pkg::sfp_event_t ev,
  output logic                busy,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [23:0]         m_tdata,
  output logic                m_tuser,
  output logic                m_tlast
);
  import sfp_pkg::*;

  typedef enum logic [1:0] {RD_IDLE, RD_ISSUE, RD_LOAD, RD_WAIT} rd_state_t;

  rd_state_t          state;
  logic [WORD_AW-1:0] rd_k;
  logic [WORD_AW-1:0] last_k;
  logic [15:0]        mem [0:WORD_DEPTH-1];
  logic [15:0]        rd_data;
  logic [15:0]        word_value;
  logic [2:0]         word_index;
  logic               frame_ok;

  assign busy    = (state != RD_IDLE) || m_tvalid;
  assign m_tdata = {5'b0, word_index, word_value};
  assign m_tuser = frame_ok;

  // Every word is written before the read of its address, so no bypass.
  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= wr.data;
    end
    rd_data <= mem[rd_k];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= RD_IDLE;
      m_tvalid <= 1'b0;
      rd_k     <= '0;
    end else begin
      unique case (state)
        RD_IDLE: begin
          if (ev.valid) begin
            rd_k   <= '0;
            last_k <= ev.last_idx;
            if (ev.ok) begin
              state <= RD_ISSUE;
            end else begin
              word_value <= '0;
              word_index <= '0;
              frame_ok   <= 1'b0;
              m_tlast    <= 1'b1;
              m_tvalid   <= 1'b1;
              state      <= RD_WAIT;
            end
          end
        end
        RD_ISSUE: state <= RD_LOAD;
        RD_LOAD: begin
          word_value <= rd_data;
          word_index <= 3'(rd_k);
          frame_ok   <= 1'b1;
          m_tlast    <= (rd_k == last_k);
          m_tvalid   <= 1'b1;
          state      <= RD_WAIT;
        end
        default: begin
          if (m_tvalid && m_tready) begin
            m_tvalid <= 1'b0;
            if (m_tlast) begin
              state <= RD_IDLE;
            end else begin
              rd_k  <= rd_k + WORD_AW'(1);
              state <= RD_ISSUE;
            end
          end
        end
      endcase
    end
  end

  a_fail_shape: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !frame_ok |-> m_tlast && word_value == '0 && word_index == '0)
    else $error("failure beat carries data");

  a_event_idle: assert property (@(posedge clk) disable iff (rst)
    ev.valid |-> state == RD_IDLE && !m_tvalid)
    else $error("frame event while readout busy");

  a_last_done: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && m_tlast |=> state == RD_IDLE && !m_tvalid)
    else $error("readout continued past last word");

  a_index_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && frame_ok |-> word_index <= 3'(last_k))
    else $error("word index beyond frame");

endmodule

// File: verif/sensor_frame_parser_sum_check_tb.sv
// Testbench for the sensor frame parser: random and directed byte streams, checked word beats.
module sensor_frame_parser_sum_check_tb;
  import sfp_pkg::*;

  localparam int SHORT_LEN = 10;
  localparam int LONG_LEN = 12;
  localparam int HALF_PERIOD = 2;
  localparam int RESET_CYCLES = 7;
  localparam int SETTLE_CYCLES = 8;      // covers the closing-byte to result latency
  localparam int HOLD_CYCLES = 300;      // long output stall
  localparam int IDLE_LIMIT = 2000;      // cycles with no beat on either side
  localparam int RANDOM_BYTES = 40;
  localparam int MAX_REPORTS = 10;

  // Parser phase of the predictor.
  typedef enum logic [1:0] {PH_HUNT, PH_HEAD2, PH_BODY} parse_phase_t;

  // One output beat as the predictor sees it.
  typedef struct packed {
    logic [15:0] word_value;
    logic [2:0]  word_index;
    logic        frame_ok;
    logic        last_word;
  } word_beat_t;

  typedef logic [7:0] byte_q_t[$];

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_we;
  logic        cfg_data;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;
  logic        m_tvalid;
  logic        m_tready;
  logic [23:0] m_tdata;
  logic        m_tuser;
  logic        m_tlast;

  // Frame predictor state, kept in step with every accepted byte.
  parse_phase_t phase_q = PH_HUNT;
  int           pos_q = 0;
  logic [15:0]  sum_q = '0;
  logic [7:0]   frame_bytes_q [STORE_DEPTH];
  logic         format_q = 1'b0;

  word_beat_t   expected_words[$];

  // Stimulus shaping shared with the output side.
  bit tx_calm = 1'b0;
  bit rx_calm = 1'b0;
  int rx_hold_req = 0;

  int errors = 0;
  int bytes_sent = 0;
  int beats_seen = 0;
  int good_frames = 0;
  int bad_frames = 0;
  int idle_cycles = 0;

  sensor_frame_parser_sum_check #(
    .SHORT_FRAME_BYTES(SHORT_LEN),
    .LONG_FRAME_BYTES (LONG_LEN)
  ) u_dut (
    .clk     (clk),
    .rst     (rst),
    .cfg_we  (cfg_we),
    .cfg_data(cfg_data),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),    // [7:0] rx_byte
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),    // [15:0] word_value, [18:16] word_index, rest zero
    .m_tuser (m_tuser),    // frame_ok
    .m_tlast (m_tlast)     // last_word
  );

  always #(HALF_PERIOD) clk = ~clk;

  // Frame length for a format: clamped to the store and rounded down to even.
  function automatic int frame_len(input logic fmt);
    int n;
    n = fmt ? LONG_LEN : SHORT_LEN;
    if (n < MIN_FRAME) n = MIN_FRAME;
    if (n > STORE_DEPTH) n = STORE_DEPTH;
    return n & ~1;
  endfunction

  // Wrapping sum over both header bytes and the payload.
  function automatic logic [15:0] frame_sum(input byte_q_t body);
    logic [15:0] s;
    s = 16'(HEADER_BYTE) + 16'(HEADER_BYTE);
    foreach (body[i]) s = s + body[i];
    return s;
  endfunction

  function automatic byte_q_t random_body(input int n);
    byte_q_t q;
    repeat (n) q.push_back(8'($urandom_range(0, 255)));
    return q;
  endfunction

  // Advance the predictor by one accepted byte and queue the beats it causes.
  task automatic predict_byte(input logic [7:0] b);
    int          flen;
    int          nwords;
    logic [15:0] rx_sum;
    flen = frame_len(format_q);
    case (phase_q)
      PH_HUNT: begin
        if (b == HEADER_BYTE) begin
          frame_bytes_q[0] = b;
          sum_q = 16'(b);
          pos_q = 1;
          phase_q = PH_HEAD2;
        end
      end
      PH_HEAD2: begin
        if (b == HEADER_BYTE) begin
          frame_bytes_q[1] = b;
          sum_q = sum_q + b;
          pos_q = 2;
          phase_q = PH_BODY;
        end else begin
          // bad second header byte: drop it and hunt again
          phase_q = PH_HUNT;
          pos_q = 0;
          sum_q = '0;
        end
      end
      default: begin
        if (pos_q >= flen || pos_q >= STORE_DEPTH) begin
          // format shrank below the position reached
          phase_q = PH_HUNT;
          pos_q = 0;
          sum_q = '0;
          expected_words.push_back('{16'h0, 3'd0, 1'b0, 1'b1});
        end else begin
          frame_bytes_q[pos_q] = b;
          if (pos_q < flen - 2) sum_q = sum_q + b;
          if (pos_q + 1 < flen) begin
            pos_q = pos_q + 1;
          end else begin
            rx_sum = {frame_bytes_q[flen-2], frame_bytes_q[flen-1]};
            nwords = (flen - 2) / 2;
            if (rx_sum != sum_q) begin
              expected_words.push_back('{16'h0, 3'd0, 1'b0, 1'b1});
            end else begin
              for (int k = 0; k < nwords; k++) begin
                expected_words.push_back('{{frame_bytes_q[2+2*k], frame_bytes_q[3+2*k]},
                                           3'(k), 1'b1, (k == nwords - 1)});
              end
            end
            phase_q = PH_HUNT;
            pos_q = 0;
            sum_q = '0;
          end
        end
      end
    endcase
  endtask

  // Offer one byte, wait for the beat, then update the predictor.
  // tvalid stays high after the beat; the next call lowers it or offers its byte, or a drain lowers it.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = tx_calm ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= b;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_byte(b);
    bytes_sent++;
  endtask

  task automatic send_bytes(input byte_q_t q);
    foreach (q[i]) send_byte(q[i]);
  endtask

  // Whole frame: header, payload, big-endian checksum (optionally damaged).
  task automatic send_frame(input byte_q_t body, input bit corrupt);
    logic [15:0] cks;
    cks = frame_sum(body);
    if (corrupt) cks = cks ^ 16'($urandom_range(1, 16'hFFFF));
    send_byte(HEADER_BYTE);
    send_byte(HEADER_BYTE);
    send_bytes(body);
    send_byte(cks[15:8]);
    send_byte(cks[7:0]);
  endtask

  // Sender pauses until every expected beat has arrived, then lets the block settle.
  task automatic drain_outputs();
    s_tvalid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // frame_format is written only once every expected word is out; a frame may be mid-collection.
  task automatic set_format(input logic fmt);
    drain_outputs();
    cfg_we <= 1'b1;
    cfg_data <= fmt;
    @(posedge clk);
    format_q = fmt;
    cfg_we <= 1'b0;
  endtask

  // Extremes: idle noise, bad header, 0x55 in payload, 0x0000/0xFFFF words,
  // a checksum failure on the long format.
  task automatic test_directed();
    set_format(1'b0);
    send_bytes('{8'h00, 8'hFF});
    send_bytes('{HEADER_BYTE, 8'h00});
    send_frame('{HEADER_BYTE, 8'hAA, 8'h00, 8'h00, 8'hFF, 8'hFF}, 1'b0);
    set_format(1'b1);
    send_frame('{8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80}, 1'b1);
  endtask

  // frame_format changed while a frame is being collected.
  task automatic test_format_switch();
    byte_q_t     body;
    logic [15:0] cks;
    // long frame cut short past the short length: one failure beat
    set_format(1'b1);
    send_bytes('{HEADER_BYTE, HEADER_BYTE});
    send_bytes(random_body(9));
    set_format(1'b0);
    send_byte(8'($urandom_range(0, 255)));
    // short frame stretched to long: five good words
    set_format(1'b0);
    body = random_body(8);
    cks = frame_sum(body);
    send_bytes('{HEADER_BYTE, HEADER_BYTE, body[0], body[1], body[2]});
    set_format(1'b1);
    send_bytes(body[3:7]);
    send_bytes('{cks[15:8], cks[7:0]});
    // long frame shortened before its checksum position: closes as a short frame
    set_format(1'b1);
    body = random_body(6);
    cks = frame_sum(body);
    send_bytes('{HEADER_BYTE, HEADER_BYTE});
    send_bytes(body);
    set_format(1'b0);
    send_bytes('{cks[15:8], cks[7:0]});
  endtask

  // Output held off for a long stretch while frames keep coming back to back,
  // then one frame with the sender waiting for every word.
  task automatic test_stall_and_drain();
    tx_calm = 1'b1;
    rx_calm = 1'b1;
    set_format(1'b1);
    rx_hold_req = HOLD_CYCLES;
    repeat (3) send_frame(random_body(frame_len(format_q) - 4), 1'b0);
    drain_outputs();
    tx_calm = 1'b0;
    rx_calm = 1'b0;
    send_frame(random_body(frame_len(format_q) - 4), 1'b0);
    drain_outputs();
  endtask

  // Mostly well-formed frames with random content; the rest is noise,
  // broken headers and bad checksums, with format changes between frames.
  task automatic test_random_stream();
    int         kind;
    int         start;
    logic [7:0] bad;
    start = bytes_sent;
    while (bytes_sent - start < RANDOM_BYTES) begin
      tx_calm = ($urandom_range(0, 3) == 0);
      rx_calm = ($urandom_range(0, 3) == 0);
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
        set_format(1'($urandom_range(0, 1)));
      end else if (kind == 1) begin
        send_bytes(random_body($urandom_range(1, 4)));
      end else if (kind == 2) begin
        // any second header byte other than 0x55
        bad = 8'($urandom_range(0, 254));
        if (bad >= HEADER_BYTE) bad = bad + 8'd1;
        send_byte(HEADER_BYTE);
        send_byte(bad);
      end else begin
        send_frame(random_body(frame_len(format_q) - 4), ($urandom_range(0, 4) == 0));
      end
    end
  endtask

  // Output side: random ready gaps, plus a long hold when a test asks for one.
  initial begin : output_side
    int gap;
    int n;
    m_tready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (rx_hold_req > 0) begin
        n = rx_hold_req;
        rx_hold_req = 0;
        m_tready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      gap = rx_calm ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
    end
  end

  // Compare every output beat with the oldest expected word, field by field.
  always @(posedge clk) begin : check_words
    word_beat_t got;
    word_beat_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = '{m_tdata[15:0], m_tdata[18:16], m_tuser, m_tlast};
      beats_seen++;
      if (!got.frame_ok) bad_frames++;
      else if (got.last_word) good_frames++;
      if (expected_words.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("unexpected beat: word %h idx %0d ok %b last %b",
                   got.word_value, got.word_index, got.frame_ok, got.last_word);
      end else begin
        want = expected_words.pop_front();
        if (got.word_value != want.word_value || got.word_index != want.word_index ||
            got.frame_ok != want.frame_ok || got.last_word != want.last_word) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("mismatch: expected word %h idx %0d ok %b last %b, got %h idx %0d ok %b last %b",
                     want.word_value, want.word_index, want.frame_ok, want.last_word,
                     got.word_value, got.word_index, got.frame_ok, got.last_word);
        end
      end
    end
  end

  // Watchdog: too long without a beat on either side means the block hung.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no beat for %0d cycles, %0d words outstanding",
                 IDLE_LIMIT, expected_words.size());
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_data <= 1'b0;
    s_tvalid <= 1'b0;
    s_tdata <= 8'h00;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_format_switch();
    test_stall_and_drain();
    test_random_stream();

    // wind down: all words back, then wait for stray beats
    drain_outputs();
    repeat (20) @(posedge clk);

    $display("covered %0d bytes in, %0d word beats out: %0d good frames, %0d failed frames",
             bytes_sent, beats_seen, good_frames, bad_frames);
    $display("both frame formats, mid-frame format changes, long output stall, %0d mismatches",
             errors);
    if (errors == 0 && expected_words.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// File: sim.f
sv/sfp_pkg.sv
sv/sfp_parser.sv
sv/sfp_readout.sv
sv/sensor_frame_parser_sum_check.sv
verif/sensor_frame_parser_sum_check_tb.sv
